[rtl/core/integer_to_ascii_formatter_macros.svh]
// assertion macros for the formatter checker
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication on i_clk, off during reset
`define ITAF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("formatter check failed");

// next-cycle implication on i_clk, off during reset
`define ITAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("formatter check failed");

`endif

[rtl/core/ito_pkg.sv]
package ito_pkg;

    localparam int MAX_FIELD_WIDTH = 64;
    localparam int DIGIT_SLOTS     = 11;
    localparam int CNT_W           = $clog2(DIGIT_SLOTS + 1);
    localparam int WID_W           = 7;
    localparam int RECIP_SHIFT     = 35;

    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    localparam logic [1:0] KIND_HEX_LO = 2'd0;
    localparam logic [1:0] KIND_HEX_UP = 2'd1;
    localparam logic [1:0] KIND_DEC_U  = 2'd2;
    localparam logic [1:0] KIND_DEC_S  = 2'd3;

    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_PLUS  = 3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [3:0]  pad_flags;
        logic [6:0]  field_width;
    } t_in;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_out;

    typedef enum logic [1:0] {
        JUST_RIGHT,
        JUST_LEFT,
        JUST_ZERO
    } t_just;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] idx;
        logic [7:0]       ch;
    } t_digit_wr;

    typedef struct packed {
        t_just            just;
        logic             has_sign;
        logic [7:0]       sign_ch;
        logic [WID_W-1:0] pad_count;
        logic [CNT_W-1:0] digit_count;
    } t_emit_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UP_A : CH_LO_A;
        if (nib >= 4'd10) begin
            hex_char = base + {4'd0, nib} - 8'd10;
        end else begin
            hex_char = CH_ZERO + {4'd0, nib};
        end
    endfunction

endpackage

[rtl/core/ito_digit_unit.sv]
module ito_digit_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [1:0]                 i_kind,
    input  logic [31:0]                i_mag,
    output ito_pkg::t_digit_wr         o_wr,
    output logic                       o_done,
    output logic [ito_pkg::CNT_W-1:0]  o_count
);
    import ito_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEX,
        S_MUL,
        S_REM
    } t_state;

    t_state             r_state;
    logic [31:0]        r_v;
    logic               r_upper;
    logic [CNT_W-1:0]   r_cnt;
    logic [63:0]        r_prod;

    logic [63-RECIP_SHIFT:0] quot;
    logic [31:0]             quot_ext;
    logic [31:0]             quot10;
    logic [31:0]             rem;

    // quotient by reciprocal multiply, remainder = v - 10 * q
    assign quot     = r_prod[63:RECIP_SHIFT];
    assign quot_ext = {{(32 - (64 - RECIP_SHIFT)){1'b0}}, quot};
    assign quot10   = (quot_ext << 3) + (quot_ext << 1);
    assign rem      = r_v - quot10;

    always_comb begin
        o_wr.en  = 1'b0;
        o_wr.idx = r_cnt;
        o_wr.ch  = CH_ZERO;
        o_done   = 1'b0;
        o_count  = r_cnt + 1'b1;
        case (r_state)
            S_HEX: begin
                o_wr.en = 1'b1;
                o_wr.ch = hex_char(r_v[3:0], r_upper);
                o_done  = (r_v[31:4] == 28'd0);
            end
            S_REM: begin
                o_wr.en = 1'b1;
                o_wr.ch = CH_ZERO + {4'd0, rem[3:0]};
                o_done  = (quot_ext == 32'd0);
            end
            default: begin
                o_wr.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_v     <= i_mag;
                        r_upper <= (i_kind == KIND_HEX_UP);
                        r_cnt   <= '0;
                        if (i_kind == KIND_HEX_LO || i_kind == KIND_HEX_UP) begin
                            r_state <= S_HEX;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_HEX: begin
                    r_v   <= r_v >> 4;
                    r_cnt <= r_cnt + 1'b1;
                    if (o_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_prod  <= {32'd0, r_v} * {32'd0, RECIP10};
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_v   <= quot_ext;
                    r_cnt <= r_cnt + 1'b1;
                    if (o_done) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/ito_emitter.sv]
module ito_emitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ito_pkg::t_digit_wr  i_wr,
    input  logic                i_start,
    input  ito_pkg::t_emit_cmd  i_cmd,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_ready,
    output ito_pkg::t_out       o_data
);
    import ito_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SIGN,
        E_PAD,
        E_DIGIT
    } t_state;

    t_state             r_state;
    logic [7:0]         r_store [DIGIT_SLOTS];
    t_emit_cmd          r_cmd;
    logic [WID_W-1:0]   r_pad;
    logic [CNT_W-1:0]   r_di;
    logic [WID_W-1:0]   r_left;
    t_out               r_out;
    logic               r_out_valid;

    t_state             n_state;
    t_state             start_state;
    logic               can_emit;
    logic               last;
    logic [7:0]         cur_ch;
    logic [CNT_W-1:0]   rd_idx;

    assign can_emit = (r_state != E_IDLE) && (!r_out_valid || i_ready);
    assign last     = (r_left == WID_W'(1));
    assign rd_idx   = r_di - 1'b1;
    assign o_busy   = (r_state != E_IDLE) || r_out_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        case (i_cmd.just)
            JUST_ZERO: begin
                if (i_cmd.has_sign) begin
                    start_state = E_SIGN;
                end else if (i_cmd.pad_count != '0) begin
                    start_state = E_PAD;
                end else begin
                    start_state = E_DIGIT;
                end
            end
            JUST_LEFT: begin
                start_state = i_cmd.has_sign ? E_SIGN : E_DIGIT;
            end
            default: begin
                if (i_cmd.pad_count != '0) begin
                    start_state = E_PAD;
                end else if (i_cmd.has_sign) begin
                    start_state = E_SIGN;
                end else begin
                    start_state = E_DIGIT;
                end
            end
        endcase
    end

    always_comb begin
        cur_ch  = CH_SPACE;
        n_state = r_state;
        case (r_state)
            E_SIGN: begin
                cur_ch = r_cmd.sign_ch;
                if (r_cmd.just == JUST_ZERO && r_pad != '0) begin
                    n_state = E_PAD;
                end else begin
                    n_state = E_DIGIT;
                end
            end
            E_PAD: begin
                cur_ch = (r_cmd.just == JUST_ZERO) ? CH_ZERO : CH_SPACE;
                if (r_pad == WID_W'(1)) begin
                    if (r_cmd.just == JUST_RIGHT && r_cmd.has_sign) begin
                        n_state = E_SIGN;
                    end else begin
                        n_state = E_DIGIT;
                    end
                end
            end
            E_DIGIT: begin
                cur_ch = r_store[rd_idx];
                if (r_di == CNT_W'(1)) begin
                    n_state = (r_cmd.just == JUST_LEFT) ? E_PAD : E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
        if (last) begin
            n_state = E_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.idx] <= i_wr.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (can_emit) begin
                r_out_valid     <= 1'b1;
                r_out.char_code <= cur_ch;
                r_out.last_char <= last;
                r_state         <= n_state;
                r_left          <= r_left - 1'b1;
                if (r_state == E_PAD) begin
                    r_pad <= r_pad - 1'b1;
                end
                if (r_state == E_DIGIT) begin
                    r_di <= r_di - 1'b1;
                end
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_start) begin
                r_cmd   <= i_cmd;
                r_pad   <= i_cmd.pad_count;
                r_di    <= i_cmd.digit_count;
                r_left  <= i_cmd.pad_count + WID_W'(i_cmd.digit_count)
                           + WID_W'(i_cmd.has_sign);
                r_state <= start_state;
            end
        end
    end

endmodule

[rtl/core/integer_to_ascii_formatter.sv]
// channel   direction  signals                      payload
// input     in         i_valid / o_ready            i_data  (kind, value, pad_flags, field_width)
// output    out        o_valid / i_ready            o_data  (char_code, last_char)
//
// one item at a time: it is taken, then the shared digit unit writes the digits (each hex
// digit in one state, each decimal digit by a multiply state, then a remainder state); the
// emitter starts on the last digit, then one character per cycle while i_ready stays high;
// the last character leaves the output register before the block returns to idle.
// reset is synchronous and active low; no clearing pass is needed.
// a stall on the output holds the character register and the emitter; no transfer is lost.
module integer_to_ascii_formatter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ito_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ito_pkg::t_out  o_data
);
    import ito_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_EMIT
    } t_state;

    t_state             r_state;
    t_just              r_just;
    logic               r_has_sign;
    logic [7:0]         r_sign_ch;
    logic [WID_W-1:0]   r_width;

    logic               accept;
    logic               neg;
    logic [31:0]        mag;
    logic [7:0]         sign_ch;
    logic               has_sign;
    t_just              just;
    logic [WID_W-1:0]   width_sat;
    logic [WID_W-1:0]   len;

    t_digit_wr          du_wr;
    logic               du_done;
    logic [CNT_W-1:0]   du_count;
    logic               em_start;
    logic               em_busy;
    t_emit_cmd          em_cmd;

    assign o_ready = (r_state == T_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        neg = (i_data.kind == KIND_DEC_S) && i_data.value[31];
        mag = neg ? (32'd0 - i_data.value) : i_data.value;
        if (neg) begin
            sign_ch = CH_MINUS;
        end else if (i_data.pad_flags[FLAG_PLUS]) begin
            sign_ch = CH_PLUS;
        end else begin
            sign_ch = CH_SPACE;
        end
        has_sign = neg || i_data.pad_flags[FLAG_PLUS] || i_data.pad_flags[FLAG_SPACE];
        if (i_data.pad_flags[FLAG_ZERO]) begin
            just = JUST_ZERO;
        end else if (i_data.pad_flags[FLAG_LEFT]) begin
            just = JUST_LEFT;
        end else begin
            just = JUST_RIGHT;
        end
        width_sat = (i_data.field_width > WID_W'(MAX_FIELD_WIDTH)) ?
                    WID_W'(MAX_FIELD_WIDTH) : i_data.field_width;
    end

    always_comb begin
        len                = WID_W'(du_count) + WID_W'(r_has_sign);
        em_cmd.just        = r_just;
        em_cmd.has_sign    = r_has_sign;
        em_cmd.sign_ch     = r_sign_ch;
        em_cmd.digit_count = du_count;
        em_cmd.pad_count   = (r_width > len) ? (r_width - len) : '0;
        em_start           = (r_state == T_CONV) && du_done;
    end

    ito_digit_unit u_digit_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_kind  (i_data.kind),
        .i_mag   (mag),
        .o_wr    (du_wr),
        .o_done  (du_done),
        .o_count (du_count)
    );

    ito_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (du_wr),
        .i_start (em_start),
        .i_cmd   (em_cmd),
        .o_busy  (em_busy),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_just     <= just;
                        r_has_sign <= has_sign;
                        r_sign_ch  <= sign_ch;
                        r_width    <= width_sat;
                        r_state    <= T_CONV;
                    end
                end
                T_CONV: begin
                    if (du_done) begin
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (!em_busy) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/ito_checker.sv]
`include "integer_to_ascii_formatter_macros.svh"

module ito_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input ito_pkg::t_in   i_data,
    input logic           o_valid,
    input logic           i_ready,
    input ito_pkg::t_out  o_data
);
    import ito_pkg::*;

    localparam logic [7:0] CH_TOP = CH_LO_A + 8'd5;

    // a stalled output transfer keeps its character
    `ITAF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_data))

    // no new item while a character is still pending
    `ITAF_ASSERT_NOW(a_no_take_while_out, o_valid, !o_ready)

    // an accepted item keeps the block busy in the next cycle
    `ITAF_ASSERT_NEXT(a_busy_after_take, i_valid && o_ready, !o_ready)

    // only space through lower f can be produced
    `ITAF_ASSERT_NOW(a_char_range, o_valid, (o_data.char_code >= CH_SPACE) && (o_data.char_code <= CH_TOP))

endmodule

bind integer_to_ascii_formatter ito_checker u_ito_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
